### rtl/assert_macros.svh
// assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KMT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define KMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/kmt_pkg.sv
package kmt_pkg;

   localparam int KEYS_DEF  = 16;
   localparam int DEPTH_DEF = 16;

   localparam logic [1:0] FUNC_PUSH = 2'd0;
   localparam logic [1:0] FUNC_POP  = 2'd1;
   localparam logic [1:0] FUNC_GET  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] key;
      logic [31:0] value;
      logic [7:0]  position;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] data_out;
   } rsp_type;

endpackage

### rtl/keyed_multivalue_table_unit.sv
// Keyed multivalue table: up to KEYS distinct 32-bit keys, each holding a chain of up to
// DEPTH values. A transaction pushes a value, pops the newest value, or gets the value at
// a one-based position counted from the oldest. One transaction is worked at a time. The
// key lookup scans the key memory one slot per cycle, and the next transaction can be
// accepted once the result of the last has been presented. A finished result waits in an
// output register while the next transaction is accepted. The slot use bits are cleared by
// reset; the key, count and value memories need no clearing.
module keyed_multivalue_table_unit #(
   parameter int KEYS  = kmt_pkg::KEYS_DEF,
   parameter int DEPTH = kmt_pkg::DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kmt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kmt_pkg::rsp_type rsp_data
);
   import kmt_pkg::*;

   localparam int IDXW = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int SCW  = $clog2(KEYS + 1);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int VN   = KEYS * DEPTH;
   localparam int VAW  = (VN > 1) ? $clog2(VN) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_COUNT = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]      state_ff, state_in;
   req_type         op_ff, op_in;
   logic [SCW-1:0]  issue_ff, issue_in;
   logic [IDXW-1:0] chk_ff, chk_in;
   logic            chk_v_ff, chk_v_in;
   logic            hit_ff, hit_in;
   logic [IDXW-1:0] hit_slot_ff, hit_slot_in;
   logic            free_ff, free_in;
   logic [IDXW-1:0] free_slot_ff, free_slot_in;
   logic [KEYS-1:0] used_ff, used_in;
   rsp_type         res_ff, res_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [31:0]     key_mem [KEYS];
   logic [CW-1:0]   cnt_mem [KEYS];
   logic [31:0]     val_mem [VN];

   logic [31:0]     key_rd_ff;
   logic [CW-1:0]   cnt_rd_ff;
   logic [31:0]     val_rd_ff;

   logic            key_we;
   logic [IDXW-1:0] key_addr;
   logic            cnt_we;
   logic [IDXW-1:0] cnt_addr;
   logic [CW-1:0]   cnt_wd;
   logic            val_we;
   logic [IDXW-1:0] val_slot;
   logic [7:0]      val_off;
   logic [VAW-1:0]  val_addr;
   logic            match;

   assign match    = used_ff[chk_ff] && (key_rd_ff == op_ff.key);
   assign val_addr = VAW'(val_slot) * VAW'(DEPTH) + VAW'(val_off);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      issue_in     = issue_ff;
      chk_in       = chk_ff;
      chk_v_in     = 1'b0;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      used_in      = used_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      key_we       = 1'b0;
      key_addr     = issue_ff[IDXW-1:0];
      cnt_we       = 1'b0;
      cnt_addr     = hit_slot_ff;
      cnt_wd       = '0;
      val_we       = 1'b0;
      val_slot     = hit_slot_ff;
      val_off      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data;
               issue_in = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue_ff != SCW'(KEYS)) begin
               chk_in   = issue_ff[IDXW-1:0];
               chk_v_in = 1'b1;
               issue_in = issue_ff + SCW'(1);
            end
            if (chk_v_ff) begin
               if (match && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_slot_in = chk_ff;
               end
               if (!used_ff[chk_ff] && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = chk_ff;
               end
               if (chk_ff == IDXW'(KEYS - 1)) begin
                  state_in = S_COUNT;
               end
            end
         end
         S_COUNT: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            res_in.status   = ST_NOT_FOUND;
            res_in.data_out = '0;
            state_in        = S_DONE;
            unique case (op_ff.func)
               FUNC_PUSH: begin
                  if (hit_ff) begin
                     if (cnt_rd_ff >= CW'(DEPTH)) begin
                        res_in.status = ST_FULL;
                     end else begin
                        val_we        = 1'b1;
                        val_off       = 8'(cnt_rd_ff);
                        cnt_we        = 1'b1;
                        cnt_wd        = cnt_rd_ff + CW'(1);
                        res_in.status = ST_OK;
                     end
                  end else if (!free_ff) begin
                     res_in.status = ST_FULL;
                  end else begin
                     key_we                = 1'b1;
                     key_addr              = free_slot_ff;
                     used_in[free_slot_ff] = 1'b1;
                     cnt_addr              = free_slot_ff;
                     cnt_we                = 1'b1;
                     cnt_wd                = CW'(1);
                     val_slot              = free_slot_ff;
                     val_we                = 1'b1;
                     res_in.status         = ST_OK;
                  end
               end
               FUNC_POP: begin
                  if (hit_ff && cnt_rd_ff != '0) begin
                     cnt_we = 1'b1;
                     cnt_wd = cnt_rd_ff - CW'(1);
                     if (cnt_rd_ff == CW'(1)) begin
                        used_in[hit_slot_ff] = 1'b0;
                     end
                     res_in.status = ST_OK;
                  end
               end
               FUNC_GET: begin
                  if (hit_ff && op_ff.position != '0 &&
                      9'(op_ff.position) <= 9'(cnt_rd_ff)) begin
                     val_off       = op_ff.position - 8'd1;
                     res_in.status = ST_OK;
                     state_in      = S_READ;
                  end
               end
               default: begin
               end
            endcase
         end
         S_READ: begin
            res_in.data_out = val_rd_ff;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_v_ff     <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_v_ff     <= chk_v_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      issue_ff     <= issue_in;
      chk_ff       <= chk_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      free_ff      <= free_in;
      free_slot_ff <= free_slot_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   // key memory
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_addr] <= op_ff.key;
      end
      if (chk_v_in) begin
         key_rd_ff <= key_mem[key_addr];
      end
   end

   // chain count memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_addr] <= cnt_wd;
      end
      cnt_rd_ff <= cnt_mem[cnt_addr];
   end

   // value memory
   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_addr] <= op_ff.value;
      end
      val_rd_ff <= val_mem[val_addr];
   end

endmodule

### rtl/kmt_checker.sv
`include "assert_macros.svh"

module kmt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input kmt_pkg::rsp_type rsp_data
);
   import kmt_pkg::*;

   logic rsp_stall;
   logic rsp_bad;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_bad   = rsp_valid && rsp_data.status != ST_OK;

   // a stalled result holds
   `KMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // data is zero unless the transaction succeeded
   `KMT_ASSERT_IMPLY(a_data_zero, clock, reset, rsp_bad, rsp_data.data_out == 32'd0)

   // one transaction at a time
   `KMT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind keyed_multivalue_table_unit kmt_checker u_kmt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### sim/keyed_multivalue_table_unit_tb.sv
`timescale 1ns / 100ps

module keyed_multivalue_table_unit_tb;
   import kmt_pkg::*;

   localparam int KEYS = KEYS_DEF;
   localparam int DEPTH = DEPTH_DEF;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1150;
   localparam int IDLE_LIMIT = 3000;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE_CYCLES = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   typedef struct {
      req_type rq;
      bit      typed;
      rsp_type rs;
   } stim_row_type;

   stim_row_type stim_rows[$];
   rsp_type      expected_rsp_q[$];

   logic [31:0] shadow_key [KEYS];
   bit          shadow_used [KEYS];
   int          shadow_count [KEYS];
   logic [31:0] shadow_value [KEYS][DEPTH];
   logic [31:0] key_pool [5];

   int errors = 0;
   int rsp_seen = 0;
   int idle_cycles = 0;
   int items_sent = 0;
   int burst_left = 0;

   always #10 clock = ~clock;

   keyed_multivalue_table_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   function automatic req_type make_req(logic [1:0] f, logic [31:0] k, logic [31:0] v,
                                        logic [7:0] p);
      req_type rq;
      rq.func     = f;
      rq.key      = k;
      rq.value    = v;
      rq.position = p;
      return rq;
   endfunction

   function automatic rsp_type predict_chain_op(req_type rq);
      rsp_type rs;
      int      slot;
      int      free_idx;
      int      pos;
      rs.status   = ST_NOT_FOUND;
      rs.data_out = '0;
      slot        = KEYS;
      free_idx    = KEYS;
      pos         = rq.position;
      for (int s = 0; s < KEYS; s++) begin
         if (slot == KEYS && shadow_used[s] && shadow_key[s] == rq.key) slot = s;
         if (free_idx == KEYS && !shadow_used[s]) free_idx = s;
      end
      case (rq.func)
         FUNC_PUSH: begin
            if (slot == KEYS) begin
               if (free_idx == KEYS) begin
                  rs.status = ST_FULL;
               end else begin
                  shadow_key[free_idx]      = rq.key;
                  shadow_used[free_idx]     = 1'b1;
                  shadow_count[free_idx]    = 1;
                  shadow_value[free_idx][0] = rq.value;
                  rs.status                 = ST_OK;
               end
            end else if (shadow_count[slot] >= DEPTH) begin
               rs.status = ST_FULL;
            end else begin
               shadow_value[slot][shadow_count[slot]] = rq.value;
               shadow_count[slot]++;
               rs.status = ST_OK;
            end
         end
         FUNC_POP: begin
            if (slot != KEYS && shadow_count[slot] > 0) begin
               shadow_count[slot]--;
               if (shadow_count[slot] == 0) shadow_used[slot] = 1'b0;
               rs.status = ST_OK;
            end
         end
         FUNC_GET: begin
            if (slot != KEYS && pos >= 1 && pos <= shadow_count[slot]) begin
               rs.data_out = shadow_value[slot][pos - 1];
               rs.status   = ST_OK;
            end
         end
         default: begin
         end
      endcase
      return rs;
   endfunction

   task automatic add_row(logic [1:0] f, logic [31:0] k, logic [31:0] v, logic [7:0] p,
                          bit typed, logic [1:0] st, logic [31:0] d);
      stim_row_type row;
      row.rq          = make_req(f, k, v, p);
      row.typed       = typed;
      row.rs.status   = st;
      row.rs.data_out = d;
      stim_rows.push_back(row);
   endtask

   task automatic send_item(req_type rq, bit typed, rsp_type rs);
      int      gap;
      rsp_type pred;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!(req_valid && req_ready));
      pred = predict_chain_op(rq);
      expected_rsp_q.push_back(typed ? rs : pred);
      if (rq.func != FUNC_UNUSED) items_sent++;
   endtask

   task automatic wait_drained();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_rsp_q.size() != 0);
   endtask

   task automatic run_chain_fill();
      logic [31:0] k;
      k = $urandom;
      for (int i = 0; i < DEPTH + 2; i++)
         send_item(make_req(FUNC_PUSH, k, $urandom, 8'($urandom_range(0, 255))), 1'b0, '0);
      for (int i = 0; i <= DEPTH + 1; i++)
         send_item(make_req(FUNC_GET, k, $urandom, 8'(i)), 1'b0, '0);
      for (int i = 0; i < DEPTH + 1; i++)
         send_item(make_req(FUNC_POP, k, $urandom, 8'($urandom_range(0, 255))), 1'b0, '0);
   endtask

   task automatic run_key_fill();
      logic [31:0] base;
      base = $urandom;
      for (int i = 0; i < KEYS + 2; i++)
         send_item(make_req(FUNC_PUSH, base + i, $urandom, 8'($urandom_range(0, 255))),
                   1'b0, '0);
      send_item(make_req(FUNC_PUSH, base, $urandom, 8'd1), 1'b0, '0);
      for (int i = 0; i < KEYS + 2; i++)
         send_item(make_req(FUNC_GET, base + i, $urandom, 8'($urandom_range(0, 2))),
                   1'b0, '0);
      for (int i = 0; i < KEYS + 2; i++)
         send_item(make_req(FUNC_POP, base + i, $urandom, 8'($urandom_range(0, 255))),
                   1'b0, '0);
   endtask

   task automatic refresh_pool();
      foreach (key_pool[i]) begin
         case ($urandom_range(0, 7))
            0: key_pool[i] = '0;
            1: key_pool[i] = '1;
            default: key_pool[i] = $urandom;
         endcase
      end
   endtask

   task automatic run_mixed();
      int          n;
      int          pick;
      logic [1:0]  f;
      logic [31:0] k;
      logic [7:0]  p;
      if ($urandom_range(0, 1) == 0) refresh_pool();
      n = $urandom_range(10, 40);
      repeat (n) begin
         pick = $urandom_range(0, 99);
         f = (pick < 40) ? FUNC_PUSH : (pick < 65) ? FUNC_POP :
             (pick < 95) ? FUNC_GET : FUNC_UNUSED;
         k = ($urandom_range(0, 19) == 0) ? $urandom : key_pool[$urandom_range(0, 4)];
         p = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, DEPTH + 1));
         send_item(make_req(f, k, $urandom, p), 1'b0, '0);
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_data.data_out, '0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.data_out !== want.data_out)
               report_mismatch("data_out", rsp_data.data_out, want.data_out);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int mode;
      int len;
      bit long_done;
      long_done = 1'b0;
      forever begin
         // long hold fills the block and backs up the request side
         if (!long_done && rsp_seen >= 150) begin
            long_done = 1'b1;
            @(posedge clock);
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         len  = $urandom_range(1, 40);
         repeat (len) begin
            @(posedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin
      for (int s = 0; s < KEYS; s++) begin
         shadow_used[s]  = 1'b0;
         shadow_count[s] = 0;
      end
      refresh_pool();

      add_row(FUNC_GET,    32'h0000_0000, 32'h0,         8'd1,   1'b1, ST_NOT_FOUND, 32'h0);
      add_row(FUNC_POP,    32'hFFFF_FFFF, 32'h0,         8'd0,   1'b1, ST_NOT_FOUND, 32'h0);
      add_row(FUNC_UNUSED, 32'h0000_0000, 32'h1234_5678, 8'd1,   1'b1, ST_NOT_FOUND, 32'h0);
      add_row(FUNC_PUSH,   32'h0000_0000, 32'hFFFF_FFFF, 8'd0,   1'b1, ST_OK,        32'h0);
      add_row(FUNC_PUSH,   32'hFFFF_FFFF, 32'h0000_0000, 8'd255, 1'b1, ST_OK,        32'h0);
      add_row(FUNC_PUSH,   32'h0000_0000, 32'hA5A5_5A5A, 8'd0,   1'b1, ST_OK,        32'h0);
      add_row(FUNC_GET,    32'h0000_0000, 32'h0,         8'd0,   1'b1, ST_NOT_FOUND, 32'h0);
      add_row(FUNC_GET,    32'h0000_0000, 32'h0,         8'd1,   1'b1, ST_OK, 32'hFFFF_FFFF);
      add_row(FUNC_GET,    32'h0000_0000, 32'h0,         8'd2,   1'b1, ST_OK, 32'hA5A5_5A5A);
      add_row(FUNC_GET,    32'h0000_0000, 32'h0,         8'd3,   1'b1, ST_NOT_FOUND, 32'h0);
      add_row(FUNC_GET,    32'h0000_0000, 32'h0,         8'd255, 1'b1, ST_NOT_FOUND, 32'h0);
      add_row(FUNC_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1,   1'b1, ST_OK,        32'h0);
      add_row(FUNC_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF, 8'd1,   1'b1, ST_NOT_FOUND, 32'h0);
      add_row(FUNC_GET,    32'h0000_0000, 32'h0,         8'd2,   1'b0, ST_OK,        32'h0);
      add_row(FUNC_POP,    32'h0000_0000, 32'h0,         8'd0,   1'b1, ST_OK,        32'h0);
      add_row(FUNC_GET,    32'h0000_0000, 32'h0,         8'd2,   1'b1, ST_NOT_FOUND, 32'h0);
      add_row(FUNC_POP,    32'h0000_0000, 32'h0,         8'd0,   1'b1, ST_OK,        32'h0);
      add_row(FUNC_GET,    32'h0000_0000, 32'h0,         8'd1,   1'b1, ST_NOT_FOUND, 32'h0);
      add_row(FUNC_POP,    32'h0000_0000, 32'h0,         8'd0,   1'b1, ST_NOT_FOUND, 32'h0);
      add_row(FUNC_POP,    32'hFFFF_FFFF, 32'h0,         8'd0,   1'b0, ST_OK,        32'h0);
      add_row(FUNC_PUSH,   32'h8000_0001, 32'h7FFF_FFFE, 8'd128, 1'b0, ST_OK,        32'h0);
      add_row(FUNC_GET,    32'h8000_0001, 32'h0,         8'd1,   1'b0, ST_OK,        32'h0);
      add_row(FUNC_POP,    32'h8000_0001, 32'h0,         8'd0,   1'b0, ST_OK,        32'h0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) send_item(stim_rows[i].rq, stim_rows[i].typed, stim_rows[i].rs);
      wait_drained();

      items_sent = 0;
      run_chain_fill();
      run_key_fill();
      while (items_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: run_chain_fill();
            1: run_key_fill();
            default: run_mixed();
         endcase
         if ($urandom_range(0, 7) == 0) wait_drained();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
